/* hdl/smd_pkg.sv */
// ----------------------------------------------------------------------------
// String message decoder package
// Shared constants, status codes and the result record of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

  // Default width of the payload byte counter.
  localparam int unsigned SmdCountBitsDefault = 32;

  // Tag bytes recognized in the message header.
  localparam logic [7:0] TagVersion = 8'hFF;
  localparam logic [7:0] TagPad     = 8'h00;
  localparam logic [7:0] TagOneByte = 8'h22;
  localparam logic [7:0] TagTwoByte = 8'h63;

  // Varint layout: seven data bits per byte, continuation in the top bit.
  localparam int unsigned VarintShift    = 7;
  localparam logic [2:0]  VarintKeepCnt  = 3'd5;
  localparam logic [2:0]  VarintSatCnt   = 3'd7;

  // Status reported with the last byte of a message.
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StTruncated = 2'd1,
    StBadTag    = 2'd2,
    StShort     = 2'd3
  } status_e;

  // One result of the decoder.
  typedef struct packed {
    logic        char_valid;
    logic [15:0] char_value;
    logic        msg_end;
    logic [1:0]  status;
  } smd_result_t;

endpackage

`default_nettype wire

/* hdl/smd_if.sv */
// ----------------------------------------------------------------------------
// String message decoder channels
// Valid/ready channels for the encoded bytes and the decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

// Encoded byte stream, one byte per transfer.
interface smd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded characters and end-of-message status, one result per transfer.
interface smd_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [15:0] char_value;
  logic        msg_end;
  logic [1:0]  status;

  modport source (output valid, output char_valid, output char_value,
                  output msg_end, output status, input ready);
  modport sink   (input valid, input char_valid, input char_value,
                  input msg_end, input status, output ready);
endinterface

`default_nettype wire

/* hdl/string_message_decoder_top.sv */
// ----------------------------------------------------------------------------
// String message decoder
// Streams one serialized string message a byte at a time and emits its
// characters and a final status.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while results are taken. Each
// accepted byte is held in an input register and decoded by the parser in
// the following cycle. Its result, if any, is written to the output
// register when the byte moves on, which waits while that register holds a
// result not yet taken; results wait there until taken. A byte yields a
// result when it completes a character or carries the last-byte mark; other
// bytes only advance the parser. The rate is set by the single parser state
// update per cycle and holds at one byte per cycle while results are taken.
`default_nettype none

module string_message_decoder_top #(
  parameter int unsigned CountBits = smd_pkg::SmdCountBitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  smd_in_if.sink     in_ch_i,
  smd_out_if.source  out_ch_o
);

  import smd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;

  logic        out_valid_q;
  smd_result_t out_q;

  smd_result_t result;
  logic        present;
  logic        out_free;
  logic        advance;

  // The held byte moves on when its result, if any, has a free slot.
  assign out_free      = ~out_valid_q | out_ch_o.ready;
  assign advance       = in_valid_q & (~present | out_free);
  assign in_ch_i.ready = ~in_valid_q | advance;

  smd_parse #(
    .CountBits (CountBits)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (advance),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .result_o  (result),
    .present_o (present)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      in_byte_q <= in_ch_i.in_byte;
      in_last_q <= in_ch_i.in_last;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && present) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && present) begin
      out_q <= result;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.char_valid = out_q.char_valid;
  assign out_ch_o.char_value = out_q.char_value;
  assign out_ch_o.msg_end    = out_q.msg_end;
  assign out_ch_o.status     = out_q.status;

endmodule

`default_nettype wire

/* hdl/smd_parse.sv */
// ----------------------------------------------------------------------------
// String message decoder parser
// Header and payload state machine; computes the result of the byte at its
// input and advances its state when that byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_parse #(
  parameter int unsigned CountBits = smd_pkg::SmdCountBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                in_last_i,
  output smd_pkg::smd_result_t     result_o,
  output logic                     present_o
);

  import smd_pkg::*;

  typedef enum logic [2:0] {
    PhTag     = 3'd0,
    PhVersion = 3'd1,
    PhCount   = 3'd2,
    PhPayload = 3'd3,
    PhDone    = 3'd4,
    PhBad     = 3'd5
  } phase_e;

  phase_e               phase_q, phase_d;
  logic                 wide_q, wide_d;
  logic [31:0]          acc_q, acc_d;
  logic [2:0]           shift_q, shift_d;
  logic [CountBits-1:0] left_q, left_d;
  logic [7:0]           low_q, low_d;
  logic                 half_q, half_d;
  logic [1:0]           err_q, err_d;

  logic [31:0]          acc_add;
  logic                 varint_end;
  logic                 char_valid;
  logic [15:0]          char_value;
  status_e              status;

  // Varint byte placed at its position; bits above 31 fall away.
  assign acc_add    = 32'(in_byte_i[6:0]) << (6'(shift_q) * 6'(VarintShift));
  assign varint_end = ~in_byte_i[7];

  // Next state and character for the byte at the input.
  always_comb begin
    phase_d    = phase_q;
    wide_d     = wide_q;
    acc_d      = acc_q;
    shift_d    = shift_q;
    left_d     = left_q;
    low_d      = low_q;
    half_d     = half_q;
    err_d      = err_q;
    char_valid = 1'b0;
    char_value = '0;

    if (phase_q == PhVersion || phase_q == PhCount) begin
      if (shift_q < VarintKeepCnt) begin
        acc_d = acc_q | acc_add;
      end
      if (shift_q < VarintSatCnt) begin
        shift_d = shift_q + 3'd1;
      end
    end

    unique case (phase_q)
      PhTag: begin
        if (in_byte_i == TagVersion) begin
          phase_d = PhVersion;
          acc_d   = '0;
          shift_d = '0;
        end else if (in_byte_i == TagPad) begin
          phase_d = PhTag;
        end else if (in_byte_i == TagOneByte || in_byte_i == TagTwoByte) begin
          wide_d  = (in_byte_i == TagTwoByte);
          phase_d = PhCount;
          acc_d   = '0;
          shift_d = '0;
        end else begin
          phase_d = PhBad;
          err_d   = StBadTag;
        end
      end
      PhVersion: begin
        if (varint_end) begin
          phase_d = PhTag;
        end
      end
      PhCount: begin
        if (varint_end) begin
          left_d = acc_d[CountBits-1:0];
          half_d = 1'b0;
          low_d  = '0;
          if (wide_q && acc_d[0]) begin
            err_d = StShort;
          end
          phase_d = (acc_d[CountBits-1:0] == '0) ? PhDone : PhPayload;
        end
      end
      PhPayload: begin
        if (wide_q) begin
          if (half_q) begin
            char_valid = 1'b1;
            char_value = {in_byte_i, low_q};
            half_d     = 1'b0;
          end else begin
            low_d  = in_byte_i;
            half_d = 1'b1;
          end
        end else begin
          char_valid = 1'b1;
          char_value = {8'h00, in_byte_i};
        end
        left_d = left_q - CountBits'(1);
        if (left_d == '0) begin
          phase_d = PhDone;
        end
      end
      PhDone, PhBad: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // End-of-message status from the phase reached by this byte.
  always_comb begin
    status = StOk;
    if (in_last_i) begin
      case (phase_d)
        PhTag, PhVersion, PhCount: status = StTruncated;
        PhPayload:                 status = StShort;
        default:                   status = status_e'(err_q | err_d);
      endcase
    end
  end

  assign result_o.char_valid = char_valid;
  assign result_o.char_value = char_value;
  assign result_o.msg_end    = in_last_i;
  assign result_o.status     = status;
  assign present_o           = char_valid | in_last_i;

  // Parser state; the last byte of a message returns it to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      wide_q  <= 1'b0;
      acc_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      low_q   <= '0;
      half_q  <= 1'b0;
      err_q   <= '0;
    end else if (take_i) begin
      if (in_last_i) begin
        phase_q <= PhTag;
        wide_q  <= 1'b0;
        acc_q   <= '0;
        shift_q <= '0;
        left_q  <= '0;
        low_q   <= '0;
        half_q  <= 1'b0;
        err_q   <= '0;
      end else begin
        phase_q <= phase_d;
        wide_q  <= wide_d;
        acc_q   <= acc_d;
        shift_q <= shift_d;
        left_q  <= left_d;
        low_q   <= low_d;
        half_q  <= half_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/string_message_decoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// String message decoder testbench
// Sends directed and random byte streams through the decoder and predicts
// every character and end-of-message status in the bench itself. Results
// are compared in order. The sender and the receiver stall at random, except in the last random run.
// ----------------------------------------------------------------------------

module string_message_decoder_top_test;
  import smd_pkg::*;

  // Header parser phases of the bench's own decoder.
  typedef enum logic [2:0] {
    PhTag,
    PhVersion,
    PhCount,
    PhPayload,
    PhDone,
    PhBad
  } parse_phase_e;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [31:0] CountMask = 32'((64'd1 << SmdCountBitsDefault) - 64'd1);
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 20;

  logic clk;
  logic rst_n;

  smd_in_if  in_ch ();
  smd_out_if out_ch ();

  string_message_decoder_top uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // Decoder state kept by the bench.
  parse_phase_e parse_phase;
  logic         wide_mode;
  logic [31:0]  varint_value;
  logic [2:0]   varint_bytes;
  logic [31:0]  payload_left;
  logic [7:0]   low_byte;
  logic         low_held;
  status_e      sticky_status;

  smd_result_t  expected_chars_q[$];
  int unsigned  error_count;
  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;
  int unsigned  stall_cycles;

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns the parser to its state at the start of a message.
  function automatic void clear_decoder_state();
    parse_phase   = PhTag;
    wide_mode     = 1'b0;
    varint_value  = '0;
    varint_bytes  = '0;
    payload_left  = '0;
    low_byte      = '0;
    low_held      = 1'b0;
    sticky_status = StOk;
  endfunction

  // Adds one base-128 byte; only the first five contribute bits.
  function automatic logic take_varint(input logic [7:0] b);
    if (varint_bytes < VarintKeepCnt) begin
      varint_value = varint_value | (32'(b[6:0]) << (VarintShift * varint_bytes));
    end
    if (varint_bytes < VarintSatCnt) begin
      varint_bytes = varint_bytes + 3'd1;
    end
    return !b[7];
  endfunction

  // Advances the parser by one byte and tells whether a result follows.
  function automatic void predict_byte(input logic [7:0] b, input logic last,
                                       output logic emit, output smd_result_t res);
    logic        char_done;
    logic [15:0] char_code;
    status_e     st;
    char_done = 1'b0;
    char_code = '0;
    st = StOk;
    case (parse_phase)
      PhTag: begin
        if (b == TagVersion) begin
          parse_phase  = PhVersion;
          varint_value = '0;
          varint_bytes = '0;
        end else if (b == TagOneByte || b == TagTwoByte) begin
          wide_mode    = (b == TagTwoByte);
          parse_phase  = PhCount;
          varint_value = '0;
          varint_bytes = '0;
        end else if (b != TagPad) begin
          parse_phase   = PhBad;
          sticky_status = StBadTag;
        end
      end
      PhVersion: begin
        if (take_varint(b)) parse_phase = PhTag;
      end
      PhCount: begin
        if (take_varint(b)) begin
          payload_left = varint_value & CountMask;
          low_held     = 1'b0;
          low_byte     = '0;
          if (wide_mode && payload_left[0]) sticky_status = StShort;
          parse_phase = (payload_left == 0) ? PhDone : PhPayload;
        end
      end
      PhPayload: begin
        if (!wide_mode) begin
          char_done = 1'b1;
          char_code = {8'h00, b};
        end else if (low_held) begin
          char_done = 1'b1;
          char_code = {b, low_byte};
          low_held  = 1'b0;
        end else begin
          low_byte = b;
          low_held = 1'b1;
        end
        payload_left = payload_left - 32'd1;
        if (payload_left == 0) parse_phase = PhDone;
      end
      default: ;
    endcase

    if (last) begin
      if (parse_phase == PhTag || parse_phase == PhVersion || parse_phase == PhCount) begin
        st = StTruncated;
      end else if (parse_phase == PhPayload) begin
        st = StShort;
      end else begin
        st = sticky_status;
      end
    end

    emit = char_done || last;
    res.char_valid = char_done;
    res.char_value = char_code;
    res.msg_end    = last;
    res.status     = st;
    if (last) clear_decoder_state();
  endfunction

  // Sends one byte, with a random gap in front, and records its prediction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic        emit;
    smd_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, last, emit, res);
    if (emit) expected_chars_q.insert(expected_chars_q.size(), res);
  endtask

  // Sends a whole message; the final byte carries the last-byte mark.
  task automatic send_message(input byte_q_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Short hand-picked messages covering the header and payload corner cases.
  task automatic test_directed_messages();
    // Version tag with a two-byte varint, padding, two-byte string with an
    // odd count: one character, then the unpaired byte gives a short status.
    send_message('{TagVersion, 8'h81, 8'h00, TagPad, TagTwoByte, 8'h03,
                   8'h41, 8'h00, 8'h7A});
    // Extreme byte values as characters, with a byte after the payload.
    send_message('{TagOneByte, 8'h02, 8'hFF, 8'h00, 8'h5A});
    // Empty string.
    send_message('{TagOneByte, 8'h00});
    // Unexpected tag; what follows is ignored.
    send_message('{8'h41, TagOneByte});
    // Nine-byte count varint: the counter saturates and the high bits drop,
    // and the message ends long before the payload does.
    send_message('{TagOneByte, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'h7F, 8'h01});
    // Message ends right on a version tag.
    send_message('{TagVersion});
  endtask

  // Mostly well-formed messages with random content, some cut short, and
  // some random noise.
  task automatic test_random_messages(input int unsigned n_bytes);
    byte_q_t     msg;
    int unsigned sent;
    int unsigned kind;
    int unsigned count;
    int unsigned groups;
    int unsigned cut;
    logic [31:0] shifted;
    logic        wide_msg;
    sent = 0;
    while (sent < n_bytes) begin
      msg.delete();
      kind = $urandom_range(99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 6)) msg.insert(msg.size(), 8'($urandom_range(255)));
      end else begin
        // Up to two padding or version tags, each version with a varint.
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(1) == 1) begin
            msg.insert(msg.size(), TagPad);
          end else begin
            msg.insert(msg.size(), TagVersion);
            repeat ($urandom_range(0, 7)) begin
              msg.insert(msg.size(), 8'h80 | 8'($urandom_range(127)));
            end
            msg.insert(msg.size(), 8'($urandom_range(127)));
          end
        end
        wide_msg = 1'($urandom_range(1));
        msg.insert(msg.size(), wide_msg ? TagTwoByte : TagOneByte);
        count = ($urandom_range(15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        if (wide_msg && $urandom_range(3) != 0) count = count & ~32'd1;
        // Count varint, sometimes with redundant continuation bytes.
        groups = 1;
        shifted = count >> 7;
        while (shifted != 0) begin
          groups++;
          shifted = shifted >> 7;
        end
        groups += ($urandom_range(5) == 0) ? $urandom_range(1, 5) : 0;
        shifted = count;
        for (int unsigned g = 0; g < groups; g++) begin
          msg.insert(msg.size(), {g != groups - 1, shifted[6:0]});
          shifted = shifted >> 7;
        end
        repeat (count) msg.insert(msg.size(), 8'($urandom_range(255)));
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom_range(255)));
        end
        if (kind < 27) begin
          cut = $urandom_range(1, msg.size());
          while (msg.size() > cut) void'(msg.pop_back());
        end
      end
      send_message(msg);
      sent += msg.size();
    end
  endtask

  // Checks one field of a result against its prediction.
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result checker and random receiver stalls.
  always @(posedge clk) begin
    smd_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual char %0b/0x%0h end %0b status %0d",
                 $time, out_ch.char_valid, out_ch.char_value, out_ch.msg_end, out_ch.status);
        error_count++;
      end else begin
        want = expected_chars_q.pop_front();
        check_field("char_valid", 16'(want.char_valid), 16'(out_ch.char_valid));
        check_field("char_value", want.char_value, out_ch.char_value);
        check_field("msg_end", 16'(want.msg_end), 16'(out_ch.msg_end));
        check_field("status", 16'(want.status), 16'(out_ch.status));
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    error_count  = 0;
    src_idle_pct = 20;
    snk_idle_pct = 53;
    clear_decoder_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_messages();
    test_random_messages(220);
    src_idle_pct = 53;
    snk_idle_pct = 20;
    test_random_messages(230);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_messages(230);

    in_ch.valid <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
